@@ rtl/mcg_pkg.sv @@
// mcg_pkg: shared types, constants and small tables of the month calendar grid block
// used by mcg_front, mcg_queue, mcg_back and month_calendar_grid; depends on nothing
`default_nettype none

package mcg_pkg;

    // navigation event codes
    localparam logic [2:0] ACT_SET        = 3'd0;
    localparam logic [2:0] ACT_YEAR_BACK  = 3'd1;
    localparam logic [2:0] ACT_YEAR_FWD   = 3'd2;
    localparam logic [2:0] ACT_MONTH_BACK = 3'd3;
    localparam logic [2:0] ACT_MONTH_FWD  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [1:0] ST_BAD_YEAR  = 2'd2;

    // calendar limits
    localparam logic [13:0] YEAR_MIN     = 14'd1;
    localparam logic [13:0] YEAR_MAX     = 14'd9999;
    localparam logic [13:0] SET_YEAR_MIN = 14'd1900;
    localparam logic [3:0]  MONTH_JAN    = 4'd1;
    localparam logic [3:0]  MONTH_FEB    = 4'd2;
    localparam logic [3:0]  MONTH_MAR    = 4'd3;
    localparam logic [3:0]  MONTH_DEC    = 4'd12;
    localparam logic [3:0]  RESET_MONTH  = 4'd1;
    localparam logic [13:0] RESET_YEAR   = 14'd1900;

    // reciprocal constants: y/100 = (y*5243)>>19 for y < 10000,
    // s/7 = (s*18725)>>17 for s < 16384
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    localparam logic [14:0] RECIP_7   = 15'd18725;
    localparam int          SHIFT_7   = 17;

    // event queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // one request handed from front to back
    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
        logic [1:0]  status;
    } t_job;

    // floor(23*m/9) for months 1..12
    function automatic logic [4:0] month_term(input logic [3:0] m);
        logic [4:0] v;
        case (m)
            4'd1:    v = 5'd2;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd10;
            4'd5:    v = 5'd12;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd17;
            4'd8:    v = 5'd20;
            4'd9:    v = 5'd23;
            4'd10:   v = 5'd25;
            4'd11:   v = 5'd28;
            4'd12:   v = 5'd30;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // days in month, february from the leap flag
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] v;
        case (m)
            4'd2:    v = leap ? 5'd29 : 5'd28;
            4'd4:    v = 5'd30;
            4'd6:    v = 5'd30;
            4'd9:    v = 5'd30;
            4'd11:   v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mcg_queue.sv @@
// mcg_queue: short flip-flop queue of requests between front and back
// depends on mcg_pkg for t_job and the queue depth
`default_nettype none

module mcg_queue
    import mcg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_rd,
    output t_job      o_job,
    output logic      o_empty
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_CW-1:0]   r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcg_front.sv @@
// mcg_front: accepts navigation events, updates the current month and year,
// and hands each event to the queue as a request; depends on mcg_pkg
`default_nettype none

module mcg_front
    import mcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [2:0]  i_action,
    input  wire logic [3:0]  i_new_month,
    input  wire logic [13:0] i_new_year,
    input  wire logic        i_q_full,
    output logic             o_q_wr,
    output t_job             o_job
);

    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [3:0]  n_month;
    logic [13:0] n_year;
    logic [1:0]  set_status;
    logic        accept;

    assign accept = i_push && !i_q_full;
    assign o_q_wr = accept;

    // validation of a set request
    always_comb begin
        set_status = ST_OK;
        if (!(i_new_month inside {[MONTH_JAN:MONTH_DEC]})) begin
            set_status = set_status | ST_BAD_MONTH;
        end
        if (!(i_new_year inside {[SET_YEAR_MIN:YEAR_MAX]})) begin
            set_status = set_status | ST_BAD_YEAR;
        end
    end

    // next month and year per event
    always_comb begin
        n_month = r_month;
        n_year  = r_year;
        case (i_action)
            ACT_SET: begin
                if (set_status == ST_OK) begin
                    n_month = i_new_month;
                    n_year  = i_new_year;
                end
            end
            ACT_YEAR_BACK: begin
                if (r_year > YEAR_MIN) n_year = r_year - 1'b1;
            end
            ACT_YEAR_FWD: begin
                if (r_year < YEAR_MAX) n_year = r_year + 1'b1;
            end
            ACT_MONTH_BACK: begin
                if (r_month <= MONTH_JAN) begin
                    if (r_year > YEAR_MIN) begin
                        n_month = MONTH_DEC;
                        n_year  = r_year - 1'b1;
                    end
                end else begin
                    n_month = r_month - 1'b1;
                end
            end
            ACT_MONTH_FWD: begin
                if (r_month >= MONTH_DEC) begin
                    if (r_year < YEAR_MAX) begin
                        n_month = MONTH_JAN;
                        n_year  = r_year + 1'b1;
                    end
                end else begin
                    n_month = r_month + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // request toward the back: rejected set carries the old date
    always_comb begin
        o_job.month  = n_month;
        o_job.year   = n_year;
        o_job.status = (i_action == ACT_SET) ? set_status : ST_OK;
    end

    // current date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month <= RESET_MONTH;
            r_year  <= RESET_YEAR;
        end else if (accept) begin
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mcg_back.sv @@
// mcg_back: takes requests from the queue, works out first weekday and month
// length, emits grid cells one per cycle unless pop stalls; depends on mcg_pkg
`default_nettype none

module mcg_back
    import mcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_job        i_job,
    input  wire logic        i_q_empty,
    output logic             o_q_rd,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [3:0]       o_shown_month,
    output logic [13:0]      o_shown_year,
    output logic [4:0]       o_cell_day,
    output logic [2:0]       o_cell_column,
    output logic [1:0]       o_status,
    output logic             o_last_cell
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SUM,
        S_MOD,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [1:0]  r_status;
    logic [13:0] r_d;
    logic [13:0] r_yy;
    logic [6:0]  r_q100_yy;
    logic [6:0]  r_q100_y;
    logic [14:0] r_sum;
    logic [2:0]  r_lead;
    logic [5:0]  r_total;
    logic [5:0]  r_cnt;
    logic [2:0]  r_col;
    logic        r_ovalid;
    logic [4:0]  r_o_day;
    logic [2:0]  r_o_col;
    logic [1:0]  r_o_status;
    logic        r_o_last;

    logic        out_ready;
    logic        early;
    logic [26:0] prod_yy;
    logic [26:0] prod_y;
    logic [14:0] sum;
    logic [29:0] prod_7;
    logic [10:0] q7;
    logic [14:0] wd_full;
    logic [2:0]  wd;
    logic [2:0]  lead;
    logic        div100;
    logic        leap;
    logic [4:0]  len;
    logic [5:0]  day_idx;
    logic [4:0]  day;
    logic        last;

    assign out_ready = !r_ovalid || i_pop;
    assign o_q_rd    = (r_state == S_IDLE) && !i_q_empty;
    assign early     = (i_job.month < MONTH_MAR);

    // divide by 100 through reciprocal multiply
    assign prod_yy = 27'(r_yy) * 27'(RECIP_100);
    assign prod_y  = 27'(r_year) * 27'(RECIP_100);

    // keith day-of-week sum before the mod 7
    assign sum = 15'(month_term(r_month)) + 15'(r_d) + 15'd4 + 15'(r_yy >> 2)
               - 15'(r_q100_yy) + 15'(r_q100_yy >> 2);

    // mod 7 through reciprocal multiply, sunday-first to monday-first lead
    assign prod_7  = 30'(r_sum) * 30'(RECIP_7);
    assign q7      = prod_7[SHIFT_7+10:SHIFT_7];
    assign wd_full = r_sum - 15'(q7) * 15'd7;
    assign wd      = wd_full[2:0];
    assign lead    = (wd == 3'd0) ? 3'd6 : wd - 3'd1;

    // gregorian leap test on the true year
    assign div100 = (r_year == 14'(r_q100_y) * 14'd100);
    assign leap   = ((r_year[1:0] == 2'b00) && !div100) || (div100 && (r_q100_y[1:0] == 2'b00));
    assign len    = month_days(r_month, leap);

    // cell contents, an error cell carries day 0
    assign day_idx = r_cnt - 6'(r_lead) + 6'd1;
    assign day     = ((r_cnt < 6'(r_lead)) || (r_status != ST_OK)) ? 5'd0 : day_idx[4:0];
    assign last    = (r_cnt == r_total - 6'd1);

    // sequencer, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_month  <= i_job.month;
                        r_year   <= i_job.year;
                        r_status <= i_job.status;
                        r_d      <= early ? i_job.year + 14'd1 : i_job.year - 14'd1;
                        r_yy     <= early ? i_job.year - 14'd1 : i_job.year;
                        r_cnt    <= '0;
                        r_col    <= '0;
                        r_lead   <= '0;
                        r_total  <= 6'd1;
                        r_state  <= (i_job.status != ST_OK) ? S_EMIT : S_DIV;
                    end
                end
                S_DIV: begin
                    r_q100_yy <= prod_yy[SHIFT_100+6:SHIFT_100];
                    r_q100_y  <= prod_y[SHIFT_100+6:SHIFT_100];
                    r_state   <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= sum;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_lead  <= lead;
                    r_total <= 6'(lead) + 6'(len);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_ready) begin
                        r_o_day    <= day;
                        r_o_col    <= r_col;
                        r_o_status <= r_status;
                        r_o_last   <= last;
                        r_cnt      <= r_cnt + 6'd1;
                        r_col      <= (r_col == 3'd6) ? 3'd0 : r_col + 3'd1;
                        if (last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (out_ready) begin
                r_ovalid <= (r_state == S_EMIT);
            end
        end
    end

    // the shown date only changes between requests, once the last cell is out
    logic [3:0]  r_o_month;
    logic [13:0] r_o_year;

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_ready) begin
            r_o_month <= r_month;
            r_o_year  <= r_year;
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_shown_month = r_o_month;
    assign o_shown_year  = r_o_year;
    assign o_cell_day    = r_o_day;
    assign o_cell_column = r_o_col;
    assign o_status      = r_o_status;
    assign o_last_cell   = r_o_last;

endmodule

`default_nettype wire

@@ rtl/month_calendar_grid.sv @@
// month_calendar_grid: top level of the month calendar grid block
// depends on mcg_pkg, mcg_front, mcg_queue and mcg_back
//
// usage:
//   input channel: drive i_action, i_new_month, i_new_year with push high;
//   the request is taken at a clock edge where push is high and full is low.
//   result channel: while empty is low the oldest cell is on the o_ ports;
//   it is taken at a clock edge where pop is high and empty is low.
// each request yields the grid of the resulting month: blank lead cells
// (day 0) then days 1..length, one cell per cycle while pop is high,
// o_last_cell on the final cell. a rejected set yields a single cell
// carrying the error status. a request passes the queue, then the back
// end steps through divide, sum and mod to emit, and each cell is held in
// the output register; a rejected set goes from idle straight to emit.
// the back end takes no new request before its last cell; the front keeps
// taking requests into a two-entry queue meanwhile.
// a stalled receiver (pop low) holds the cell on the ports and stalls the
// back end; the front keeps taking requests until the queue fills.
// reset (synchronous, active low) sets january 1900 and empties everything.
`default_nettype none

module month_calendar_grid
    import mcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_action,
    input  wire logic [3:0]  i_new_month,
    input  wire logic [13:0] i_new_year,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_shown_month,
    output logic [13:0]      o_shown_year,
    output logic [4:0]       o_cell_day,
    output logic [2:0]       o_cell_column,
    output logic [1:0]       o_status,
    output logic             o_last_cell
);

    t_job q_in;
    t_job q_out;
    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;

    assign full = q_full;

    // event front end
    mcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_new_month (i_new_month),
        .i_new_year  (i_new_year),
        .i_q_full    (q_full),
        .o_q_wr      (q_wr),
        .o_job       (q_in)
    );

    // request queue
    mcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_job   (q_out),
        .o_empty (q_empty)
    );

    // grid back end
    mcg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (q_out),
        .i_q_empty     (q_empty),
        .o_q_rd        (q_rd),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_shown_month (o_shown_month),
        .o_shown_year  (o_shown_year),
        .o_cell_day    (o_cell_day),
        .o_cell_column (o_cell_column),
        .o_status      (o_status),
        .o_last_cell   (o_last_cell)
    );

endmodule

`default_nettype wire

@@ sim/month_calendar_grid_test.sv @@
`timescale 1ns / 100ps
// month_calendar_grid_test: self-checking bench for the month calendar grid block
// predicts every grid cell per navigation request; depends on mcg_pkg and month_calendar_grid

module month_calendar_grid_test;
    import mcg_pkg::*;

    // codes the package does not name
    localparam logic [2:0] ACT_REDRAW  = 3'd5;
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;
    localparam logic [1:0] ST_BOTH_BAD = ST_BAD_MONTH | ST_BAD_YEAR;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [3:0]  month;
        logic [13:0] year;
        logic [4:0]  day;
        logic [2:0]  column;
        logic [1:0]  status;
        logic        last;
    } t_grid_cell;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [2:0]  i_action = '0;
    logic [3:0]  i_new_month = '0;
    logic [13:0] i_new_year = '0;
    logic        full;
    logic        empty;
    logic [3:0]  o_shown_month;
    logic [13:0] o_shown_year;
    logic [4:0]  o_cell_day;
    logic [2:0]  o_cell_column;
    logic [1:0]  o_status;
    logic        o_last_cell;

    // predicted calendar state and cells still owed by the block
    logic [3:0]  view_month = RESET_MONTH;
    logic [13:0] view_year = RESET_YEAR;
    t_grid_cell  pending_cells[$];

    int err_count = 0;
    int requests_sent = 0;
    int cells_seen = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int quiet_cycles = 0;

    month_calendar_grid uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_new_month   (i_new_month),
        .i_new_year    (i_new_year),
        .empty         (empty),
        .pop           (pop),
        .o_shown_month (o_shown_month),
        .o_shown_year  (o_shown_year),
        .o_cell_day    (o_cell_day),
        .o_cell_column (o_cell_column),
        .o_status      (o_status),
        .o_last_cell   (o_last_cell)
    );

    always #5 i_clk = ~i_clk;

    // gregorian leap rule
    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            2:              return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:    return 30;
            default:        return 31;
        endcase
    endfunction

    // blank cells before day 1, monday-first, from keith's weekday formula
    function automatic int lead_blanks(int m, int y);
        int d;
        int yy;
        int wd;
        yy = y;
        if (m < 3) begin
            d = 1 + yy;
            yy = (yy > 0) ? yy - 1 : 0;
        end else begin
            d = yy - 1;
        end
        wd = ((23 * m) / 9 + d + 4 + yy / 4 - yy / 100 + yy / 400) % 7;
        return (wd == 0) ? 6 : wd - 1;
    endfunction

    // apply one request to the predicted state and queue the cells it yields
    function automatic void predict_month_grid(logic [2:0] act, logic [3:0] nm,
                                               logic [13:0] ny);
        logic [1:0] err;
        int lead;
        int total;
        t_grid_cell c;
        err = ST_OK;
        case (act)
            ACT_SET: begin
                if (nm < MONTH_JAN || nm > MONTH_DEC) err |= ST_BAD_MONTH;
                if (ny < SET_YEAR_MIN || ny > YEAR_MAX) err |= ST_BAD_YEAR;
                if (err == ST_OK) begin
                    view_month = nm;
                    view_year = ny;
                end
            end
            ACT_YEAR_BACK: if (view_year > YEAR_MIN) view_year--;
            ACT_YEAR_FWD:  if (view_year < YEAR_MAX) view_year++;
            ACT_MONTH_BACK: begin
                if (view_month <= MONTH_JAN) begin
                    if (view_year > YEAR_MIN) begin
                        view_month = MONTH_DEC;
                        view_year--;
                    end
                end else begin
                    view_month--;
                end
            end
            ACT_MONTH_FWD: begin
                if (view_month >= MONTH_DEC) begin
                    if (view_year < YEAR_MAX) begin
                        view_month = MONTH_JAN;
                        view_year++;
                    end
                end else begin
                    view_month++;
                end
            end
            default: ;
        endcase
        // rejected set: one error cell, state kept
        if (err != ST_OK) begin
            c = '{view_month, view_year, 5'd0, 3'd0, err, 1'b1};
            pending_cells.push_back(c);
            return;
        end
        lead = lead_blanks(view_month, view_year);
        total = lead + days_in_month(view_month, view_year);
        for (int i = 0; i < total; i++) begin
            c.month = view_month;
            c.year = view_year;
            c.day = (i < lead) ? 5'd0 : 5'(i - lead + 1);
            c.column = 3'(i % 7);
            c.status = ST_OK;
            c.last = (i == total - 1);
            pending_cells.push_back(c);
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < 60) $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("cell %0d %s got %0d expected %0d",
                                      cells_seen, name, got, want));
    endtask

    // predict on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            predict_month_grid(i_action, i_new_month, i_new_year);
            requests_sent++;
        end
    end

    // compare each popped cell with the oldest prediction
    always @(posedge i_clk) begin : check_cells
        t_grid_cell want;
        if (i_rst_n && pop && !empty) begin
            if (pending_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected cell %0d/%0d day %0d",
                                          o_shown_month, o_shown_year, o_cell_day));
            end else begin
                want = pending_cells.pop_front();
                check_field("shown_month", o_shown_month, want.month);
                check_field("shown_year", o_shown_year, want.year);
                check_field("cell_day", o_cell_day, want.day);
                check_field("cell_column", o_cell_column, want.column);
                check_field("status", o_status, want.status);
                check_field("last_cell", o_last_cell, want.last);
            end
            cells_seen++;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // send one request, idling at random before and while offering it
    task automatic send_request(logic [2:0] act, logic [3:0] nm, logic [13:0] ny);
        bit taken;
        taken = 0;
        if (send_idle_pct != 0 && $urandom_range(15) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(45, 1)) @(posedge i_clk);
        end
        while (!taken) begin
            if ($urandom_range(99) < send_idle_pct) begin
                push <= 1'b0;
            end else begin
                push <= 1'b1;
                i_action <= act;
                i_new_month <= nm;
                i_new_year <= ny;
            end
            @(posedge i_clk);
            if (push && !full) taken = 1;
        end
    endtask

    // hold off the sender until every predicted cell has come out
    task automatic wait_for_grid_drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_view();
        send_request(ACT_REDRAW, 4'd0, 14'd0);
    endtask

    // leap februaries, every rejection code, year field above range
    task automatic test_set_checks();
        send_request(ACT_SET, MONTH_FEB, 14'd2000);
        send_request(ACT_SET, MONTH_FEB, 14'd1900);
        send_request(ACT_SET, MONTH_FEB, 14'd2024);
        send_request(ACT_SET, 4'd0, 14'd2000);
        send_request(ACT_SET, 4'd13, 14'd2000);
        send_request(ACT_SET, 4'd15, 14'd1899);
        send_request(ACT_SET, MONTH_DEC, 14'd10000);
        send_request(ACT_SET, MONTH_DEC, 14'h3fff);
        send_request(ACT_SET, 4'd0, 14'd0);
    endtask

    // month wraps across years, year steps and spare codes
    task automatic test_steps_and_wraps();
        send_request(ACT_SET, MONTH_JAN, 14'd2000);
        send_request(ACT_MONTH_BACK, 4'd0, 14'd0);
        send_request(ACT_MONTH_FWD, 4'd0, 14'd0);
        send_request(ACT_YEAR_BACK, 4'd15, 14'h3fff);
        send_request(ACT_YEAR_FWD, 4'd0, 14'd0);
        send_request(ACT_SPARE_A, 4'd0, 14'd0);
        send_request(ACT_SPARE_B, 4'd15, 14'h3fff);
    endtask

    // saturation and held month step at december 9999
    task automatic test_upper_limits();
        send_request(ACT_SET, MONTH_DEC, YEAR_MAX);
        send_request(ACT_YEAR_FWD, 4'd0, 14'd0);
        send_request(ACT_MONTH_FWD, 4'd0, 14'd0);
        send_request(ACT_MONTH_BACK, 4'd0, 14'd0);
    endtask

    // steps below the lowest settable year, then back across the wrap
    task automatic test_lower_limits();
        send_request(ACT_SET, MONTH_JAN, SET_YEAR_MIN);
        send_request(ACT_MONTH_BACK, 4'd0, 14'd0);
        repeat (3) send_request(ACT_YEAR_BACK, 4'd0, 14'd0);
        send_request(ACT_MONTH_FWD, 4'd0, 14'd0);
        send_request(ACT_MONTH_FWD, 4'd0, 14'd0);
    endtask

    // mostly valid navigation with random content, some malformed sets
    task automatic test_random_traffic(int count);
        logic [2:0]  act;
        logic [3:0]  nm;
        logic [13:0] ny;
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            act = $urandom_range(7);
            nm = $urandom_range(15);
            ny = $urandom_range(16383);
            if (pick < 28) begin
                act = ACT_SET;
                nm = $urandom_range(12, 1);
                ny = $urandom_range(9999, 1900);
            end else if (pick < 33) begin
                act = ACT_SET;
                nm = $urandom_range(12, 1);
                ny = ($urandom_range(1)) ? YEAR_MAX : SET_YEAR_MIN;
            end else if (pick < 43) begin
                act = ACT_SET;
            end else if (pick < 94) begin
                act = $urandom_range(5, 1);
            end
            send_request(act, nm, ny);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_view();
        test_set_checks();
        wait_for_grid_drain();
        test_steps_and_wraps();
        test_upper_limits();
        test_lower_limits();
        wait_for_grid_drain();

        // flow-control phases: none, sender idle, receiver stall, both
        send_idle_pct = 0;  pop_stall_pct = 0;
        test_random_traffic(43);
        send_idle_pct = 62; pop_stall_pct = 0;
        test_random_traffic(43);
        wait_for_grid_drain();
        send_idle_pct = 0;  pop_stall_pct = 62;
        test_random_traffic(43);
        send_idle_pct = 27; pop_stall_pct = 27;
        test_random_traffic(43);
        wait_for_grid_drain();

        if (pending_cells.size() != 0)
            report_mismatch($sformatf("%0d cells never arrived", pending_cells.size()));
        $display("run covered %0d navigation requests and %0d grid cells,",
                 requests_sent, cells_seen);
        $display("including set rejections, the 9999 year limit, month wraps and four flow-control phases");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mcg_pkg.sv
rtl/mcg_queue.sv
rtl/mcg_front.sv
rtl/mcg_back.sv
rtl/month_calendar_grid.sv
sim/month_calendar_grid_test.sv
